[design/chrm_pkg.sv]
// Package of shared types and constants for the cache hit rate monitor.
`default_nettype none
package chrm_pkg;

    localparam int unsigned WINDOW_SAMPLES_DEFAULT = 16;

    localparam logic [31:0] TICKS_RESET = 32'd10000000;
    localparam logic [7:0]  LIMIT_RESET = 8'd3;

    localparam logic [39:0] RATE_CAP   = 40'd1000000000000;
    localparam logic [13:0] RATIO_FULL = 14'd10000;

    localparam int unsigned RATE_STEPS  = 96;
    localparam int unsigned RATIO_STEPS = 80;
    localparam int unsigned RATIO_SHIFT = 16;

    typedef enum logic [1:0] {
        OP_GOOD = 2'd0,
        OP_FAIL = 2'd1,
        OP_IDLE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        REG_TICKS = 1'b0,
        REG_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        JOB_READ  = 2'd0,
        JOB_HIT   = 2'd1,
        JOB_MISS  = 2'd2,
        JOB_RATIO = 2'd3
    } job_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WIN   = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_MLO   = 8'b0000_1000,
        ST_MHI   = 8'b0001_0000,
        ST_MADD  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_STORE = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic        valid;
        logic        rate_ok;
        logic        ratio_ok;
        logic [39:0] rd_bps;
        logic [39:0] hit_bps;
        logic [39:0] miss_bps;
        logic [13:0] ratio;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

[design/chrm_ram.sv]
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module chrm_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/cache_hit_rate_monitor.sv]
// A good sample that computes rates runs a window update, then three rate divisions and a ratio
// division on the shared divider, which yields one quotient bit per cycle.
// An empty window or a full hit count skips the ratio division and ends after the miss rate.
// Other results appear in the cycle after the accept; a failure that starts a run and reaches
// the limit adds a second once the first beat is taken. One item is in work at a time.
// Reset (rst_n, asynchronous, active low) clears all state; the window empties via its fill count.
`default_nettype none
module cache_hit_rate_monitor #(
    parameter int unsigned WINDOW_SAMPLES = chrm_pkg::WINDOW_SAMPLES_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // total bytes[63:0], cached bytes[127:64], elapsed ticks[159:128]
    input  wire logic [159:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_tuser,
    // Output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // read rate[39:0], hit rate[79:40], miss rate[119:80],
    // hit ratio[133:120], zero fill[135:134]
    output logic      [135:0] m_tdata,
    // snapshot valid[0], rates valid[1], ratio valid[2]
    output logic      [2:0]   m_tuser,
    output logic              m_tlast
);

    localparam int unsigned SLOT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int unsigned FILL_W = $clog2(WINDOW_SAMPLES + 1);

    chrm_pkg::state_t  state_reg;
    chrm_pkg::job_t    job_reg;
    chrm_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              pend_reg;

    logic [31:0]       ticks_reg;
    logic [7:0]        limit_reg;

    logic [63:0]       base_total_reg;
    logic [63:0]       base_cached_reg;
    logic              have_base_reg;
    logic              active_reg;
    logic [7:0]        fail_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [63:0]       sum_reads_reg;
    logic [63:0]       sum_hits_reg;
    logic [39:0]       shown_rs_reg;
    logic [39:0]       shown_hs_reg;
    logic [39:0]       shown_ms_reg;
    logic [13:0]       shown_ratio_reg;

    logic [63:0]       dr_reg;
    logic [63:0]       dh_reg;
    logic [63:0]       dm_reg;
    logic [31:0]       elapsed_reg;
    logic [39:0]       rs_reg;
    logic [39:0]       hs_reg;
    logic [39:0]       ms_reg;

    logic [63:0]       op_a_reg;
    logic [31:0]       op_b_reg;
    logic [63:0]       prod_reg;
    logic [95:0]       acc_reg;
    logic [63:0]       div_d_reg;
    logic [63:0]       rem_reg;
    logic [95:0]       quot_reg;
    logic [6:0]        count_reg;

    // Configuration
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (chrm_pkg::reg_idx_t'(paddr[2]) == chrm_pkg::REG_LIMIT)
                  ? {24'd0, limit_reg} : ticks_reg;

    // Input decode
    logic [63:0] in_total;
    logic [63:0] in_cached;
    logic [31:0] in_elapsed;
    chrm_pkg::op_t in_op;
    logic        in_acc;
    logic [63:0] dr_calc;
    logic [63:0] dh_calc;
    logic [7:0]  fail_inc;

    assign in_total   = s_tdata[63:0];
    assign in_cached  = s_tdata[127:64];
    assign in_elapsed = s_tdata[159:128];
    assign in_op      = chrm_pkg::op_t'(s_tuser);
    assign s_tready   = (state_reg == chrm_pkg::ST_IDLE) && !out_valid_reg;
    assign in_acc     = s_tvalid && s_tready;
    assign dr_calc    = (in_total >= base_total_reg) ? in_total - base_total_reg : 64'd0;
    assign dh_calc    = (in_cached >= base_cached_reg) ? in_cached - base_cached_reg : 64'd0;
    assign fail_inc   = (fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1;

    // Window store: reads in the low half, hits in the high half
    logic [127:0] win_rdata;
    logic         win_we;
    logic         entry_ok;
    logic [63:0]  old_r;
    logic [63:0]  old_h;

    assign win_we   = (state_reg == chrm_pkg::ST_WIN);
    assign entry_ok = fill_reg > FILL_W'(slot_reg);
    assign old_r    = entry_ok ? win_rdata[63:0] : 64'd0;
    assign old_h    = entry_ok ? win_rdata[127:64] : 64'd0;

    chrm_ram #(
        .WIDTH (128),
        .DEPTH (WINDOW_SAMPLES),
        .AW    (SLOT_W)
    ) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (slot_reg),
        .wdata ({dh_reg, dr_reg}),
        .raddr (slot_reg),
        .rdata (win_rdata)
    );

    // Shared multiplier and divider step
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [95:0] acc_sum;
    logic [64:0] div_r2;
    logic        div_ge;
    logic [64:0] div_diff;
    logic [39:0] rate_capped;
    logic [13:0] quick_ratio;

    assign mul_a       = (state_reg == chrm_pkg::ST_MLO) ? op_a_reg[31:0] : op_a_reg[63:32];
    assign mul_p       = mul_a * op_b_reg;
    assign acc_sum     = acc_reg + {prod_reg, 32'd0};
    assign div_r2      = {rem_reg, quot_reg[95]};
    assign div_ge      = div_r2 >= {1'b0, div_d_reg};
    assign div_diff    = div_r2 - {1'b0, div_d_reg};
    assign rate_capped = (quot_reg > 96'(chrm_pkg::RATE_CAP)) ? chrm_pkg::RATE_CAP
                                                               : quot_reg[39:0];
    assign quick_ratio = (sum_reads_reg == 64'd0) ? 14'd0 : chrm_pkg::RATIO_FULL;

    function automatic chrm_pkg::result_t zero_result(input logic last);
        chrm_pkg::result_t r;
        r       = '0;
        r.valid = 1'b1;
        r.last  = last;
        return r;
    endfunction

    function automatic chrm_pkg::result_t make_result(
        input logic        v,
        input logic        rok,
        input logic        qok,
        input logic [39:0] rs,
        input logic [39:0] hs,
        input logic [39:0] ms,
        input logic [13:0] q,
        input logic        last
    );
        chrm_pkg::result_t r;
        r.valid    = v;
        r.rate_ok  = rok;
        r.ratio_ok = qok;
        r.rd_bps   = rs;
        r.hit_bps  = hs;
        r.miss_bps = ms;
        r.ratio    = q;
        r.last     = last;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= chrm_pkg::ST_IDLE;
            job_reg         <= chrm_pkg::JOB_READ;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            ticks_reg       <= chrm_pkg::TICKS_RESET;
            limit_reg       <= chrm_pkg::LIMIT_RESET;
            base_total_reg  <= '0;
            base_cached_reg <= '0;
            have_base_reg   <= 1'b0;
            active_reg      <= 1'b0;
            fail_reg        <= '0;
            slot_reg        <= '0;
            fill_reg        <= '0;
            sum_reads_reg   <= '0;
            sum_hits_reg    <= '0;
            shown_rs_reg    <= '0;
            shown_hs_reg    <= '0;
            shown_ms_reg    <= '0;
            shown_ratio_reg <= '0;
            dr_reg          <= '0;
            dh_reg          <= '0;
            dm_reg          <= '0;
            elapsed_reg     <= '0;
            rs_reg          <= '0;
            hs_reg          <= '0;
            ms_reg          <= '0;
            op_a_reg        <= '0;
            op_b_reg        <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            div_d_reg       <= '0;
            rem_reg         <= '0;
            quot_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (chrm_pkg::reg_idx_t'(paddr[2]))
                    chrm_pkg::REG_TICKS: ticks_reg <= pwdata;
                    chrm_pkg::REG_LIMIT: limit_reg <= pwdata[7:0];
                    default: ;
                endcase
            end

            // Output beat; a pending second beat republishes the last shown snapshot.
            if (out_valid_reg && m_tready)
            begin
                if (pend_reg)
                begin
                    pend_reg <= 1'b0;
                    out_reg  <= make_result(1'b0, 1'b0, 1'b0, shown_rs_reg, shown_hs_reg,
                                            shown_ms_reg, shown_ratio_reg, 1'b1);
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end

            case (state_reg)
                chrm_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_op)
                            chrm_pkg::OP_IDLE:
                            begin
                                if (active_reg)
                                begin
                                    out_reg         <= zero_result(1'b1);
                                    out_valid_reg   <= 1'b1;
                                    shown_rs_reg    <= '0;
                                    shown_hs_reg    <= '0;
                                    shown_ms_reg    <= '0;
                                    shown_ratio_reg <= '0;
                                end
                                active_reg      <= 1'b0;
                                have_base_reg   <= 1'b0;
                                base_total_reg  <= '0;
                                base_cached_reg <= '0;
                                fail_reg        <= '0;
                                slot_reg        <= '0;
                                fill_reg        <= '0;
                                sum_reads_reg   <= '0;
                                sum_hits_reg    <= '0;
                            end
                            chrm_pkg::OP_FAIL:
                            begin
                                fail_reg   <= fail_inc;
                                active_reg <= 1'b1;
                                if (!active_reg)
                                begin
                                    out_reg         <= zero_result(!(fail_inc >= limit_reg));
                                    out_valid_reg   <= 1'b1;
                                    pend_reg        <= fail_inc >= limit_reg;
                                    shown_rs_reg    <= '0;
                                    shown_hs_reg    <= '0;
                                    shown_ms_reg    <= '0;
                                    shown_ratio_reg <= '0;
                                end
                                else if (fail_inc >= limit_reg)
                                begin
                                    out_reg       <= make_result(1'b0, 1'b0, 1'b0,
                                                                 shown_rs_reg, shown_hs_reg,
                                                                 shown_ms_reg, shown_ratio_reg,
                                                                 1'b1);
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            chrm_pkg::OP_GOOD:
                            begin
                                base_total_reg  <= in_total;
                                base_cached_reg <= in_cached;
                                have_base_reg   <= 1'b1;
                                fail_reg        <= '0;
                                active_reg      <= 1'b1;
                                dr_reg          <= dr_calc;
                                dh_reg          <= dh_calc;
                                dm_reg          <= (dr_calc >= dh_calc) ? dr_calc - dh_calc
                                                                        : 64'd0;
                                elapsed_reg     <= in_elapsed;
                                if (active_reg && have_base_reg && (in_elapsed != 32'd0))
                                begin
                                    state_reg <= chrm_pkg::ST_WIN;
                                end
                                else
                                begin
                                    out_reg         <= zero_result(1'b1);
                                    out_valid_reg   <= 1'b1;
                                    shown_rs_reg    <= '0;
                                    shown_hs_reg    <= '0;
                                    shown_ms_reg    <= '0;
                                    shown_ratio_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                chrm_pkg::ST_WIN:
                begin
                    sum_reads_reg <= sum_reads_reg - old_r + dr_reg;
                    sum_hits_reg  <= sum_hits_reg - old_h + dh_reg;
                    slot_reg      <= (slot_reg == SLOT_W'(WINDOW_SAMPLES - 1))
                                   ? '0 : slot_reg + 1'b1;
                    if (fill_reg != FILL_W'(WINDOW_SAMPLES))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    job_reg   <= chrm_pkg::JOB_READ;
                    state_reg <= chrm_pkg::ST_LOAD;
                end
                chrm_pkg::ST_LOAD:
                begin
                    op_b_reg <= (job_reg == chrm_pkg::JOB_RATIO) ? 32'(chrm_pkg::RATIO_FULL)
                                                                 : ticks_reg;
                    case (job_reg)
                        chrm_pkg::JOB_READ:
                        begin
                            op_a_reg  <= dr_reg;
                            state_reg <= chrm_pkg::ST_MLO;
                        end
                        chrm_pkg::JOB_HIT:
                        begin
                            op_a_reg  <= dh_reg;
                            state_reg <= chrm_pkg::ST_MLO;
                        end
                        chrm_pkg::JOB_MISS:
                        begin
                            op_a_reg  <= dm_reg;
                            state_reg <= chrm_pkg::ST_MLO;
                        end
                        default:
                        begin
                            op_a_reg <= sum_hits_reg;
                            // An empty window or a full hit count needs no division.
                            if ((sum_reads_reg == 64'd0) || (sum_hits_reg >= sum_reads_reg))
                            begin
                                out_reg         <= make_result(1'b1, 1'b1,
                                                               sum_reads_reg != 64'd0,
                                                               rs_reg, hs_reg, ms_reg,
                                                               quick_ratio, 1'b1);
                                out_valid_reg   <= 1'b1;
                                shown_rs_reg    <= rs_reg;
                                shown_hs_reg    <= hs_reg;
                                shown_ms_reg    <= ms_reg;
                                shown_ratio_reg <= quick_ratio;
                                state_reg       <= chrm_pkg::ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= chrm_pkg::ST_MLO;
                            end
                        end
                    endcase
                end
                chrm_pkg::ST_MLO:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= chrm_pkg::ST_MHI;
                end
                chrm_pkg::ST_MHI:
                begin
                    acc_reg   <= {32'd0, prod_reg};
                    prod_reg  <= mul_p;
                    state_reg <= chrm_pkg::ST_MADD;
                end
                chrm_pkg::ST_MADD:
                begin
                    rem_reg <= '0;
                    if (job_reg == chrm_pkg::JOB_RATIO)
                    begin
                        div_d_reg <= sum_reads_reg;
                        quot_reg  <= acc_sum << chrm_pkg::RATIO_SHIFT;
                        count_reg <= 7'(chrm_pkg::RATIO_STEPS);
                    end
                    else
                    begin
                        div_d_reg <= {32'd0, elapsed_reg};
                        quot_reg  <= acc_sum;
                        count_reg <= 7'(chrm_pkg::RATE_STEPS);
                    end
                    state_reg <= chrm_pkg::ST_DIV;
                end
                chrm_pkg::ST_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    rem_reg   <= div_ge ? div_diff[63:0] : div_r2[63:0];
                    quot_reg  <= {quot_reg[94:0], div_ge};
                    count_reg <= count_reg - 7'd1;
                    if (count_reg == 7'd1)
                    begin
                        state_reg <= chrm_pkg::ST_STORE;
                    end
                end
                chrm_pkg::ST_STORE:
                begin
                    case (job_reg)
                        chrm_pkg::JOB_READ:
                        begin
                            rs_reg    <= rate_capped;
                            job_reg   <= chrm_pkg::JOB_HIT;
                            state_reg <= chrm_pkg::ST_LOAD;
                        end
                        chrm_pkg::JOB_HIT:
                        begin
                            hs_reg    <= rate_capped;
                            job_reg   <= chrm_pkg::JOB_MISS;
                            state_reg <= chrm_pkg::ST_LOAD;
                        end
                        chrm_pkg::JOB_MISS:
                        begin
                            ms_reg    <= rate_capped;
                            job_reg   <= chrm_pkg::JOB_RATIO;
                            state_reg <= chrm_pkg::ST_LOAD;
                        end
                        default:
                        begin
                            out_reg         <= make_result(1'b1, 1'b1, 1'b1, rs_reg, hs_reg,
                                                           ms_reg, quot_reg[13:0], 1'b1);
                            out_valid_reg   <= 1'b1;
                            shown_rs_reg    <= rs_reg;
                            shown_hs_reg    <= hs_reg;
                            shown_ms_reg    <= ms_reg;
                            shown_ratio_reg <= quot_reg[13:0];
                            state_reg       <= chrm_pkg::ST_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= chrm_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.ratio, out_reg.miss_bps, out_reg.hit_bps,
                       out_reg.rd_bps};
    assign m_tuser  = {out_reg.ratio_ok, out_reg.rate_ok, out_reg.valid};
    assign m_tlast  = out_reg.last;

    // A beat in flight blocks new items.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input accepted while a result waits");

    // A pending second beat means the current one is not the last of its run.
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && pend_reg) |-> !m_tlast)
        else $error("first of two results marked last");

    // The ratio never exceeds one hundred percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.ratio <= chrm_pkg::RATIO_FULL))
        else $error("hit ratio out of range");

    // The fill count never passes the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_SAMPLES))
        else $error("window fill count overflow");

endmodule
`default_nettype wire

[verif/tb_cache_hit_rate_monitor.sv]
// Self-checking testbench for the cache hit rate monitor: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 100ps
module tb_cache_hit_rate_monitor;

    typedef struct packed {
        logic        snap_ok;
        logic        rate_ok;
        logic        ratio_ok;
        logic [39:0] rd_bps;
        logic [39:0] hit_bps;
        logic [39:0] miss_bps;
        logic [13:0] ratio;
        logic        last;
    } snapshot_t;

    class rate_scoreboard;
        bit [31:0]  tick_hz;
        bit [7:0]   fail_limit;
        bit [63:0]  prev_total;
        bit [63:0]  prev_cached;
        bit         has_prev;
        bit         active;
        bit [7:0]   fails;
        bit [63:0]  ring_rd [chrm_pkg::WINDOW_SAMPLES_DEFAULT];
        bit [63:0]  ring_hit [chrm_pkg::WINDOW_SAMPLES_DEFAULT];
        int         slot;
        bit [63:0]  total_rd;
        bit [63:0]  total_hit;
        bit [39:0]  last_bps [3];
        bit [13:0]  last_ratio;
        snapshot_t  pending [$];
        int         errors;

        function new();
            tick_hz = chrm_pkg::TICKS_RESET;
            fail_limit = chrm_pkg::LIMIT_RESET;
            clear_ring();
            has_prev = 0;
            active = 0;
            fails = 0;
            prev_total = 0;
            prev_cached = 0;
            last_bps = '{default: 0};
            last_ratio = 0;
            errors = 0;
        endfunction

        function void clear_ring();
            ring_rd = '{default: 0};
            ring_hit = '{default: 0};
            slot = 0;
            total_rd = 0;
            total_hit = 0;
        endfunction

        // floor(num / den) capped; the 128-bit product cannot overflow here.
        function bit [63:0] capped_div(bit [127:0] num, bit [63:0] den, bit [63:0] cap);
            bit [127:0] q;
            q = num / den;
            return (q > cap) ? cap : q[63:0];
        endfunction

        function bit [39:0] speed(bit [63:0] delta, bit [31:0] el);
            return 40'(capped_div(128'(delta) * 128'(tick_hz), 64'(el),
                                  64'(chrm_pkg::RATE_CAP)));
        endfunction

        function void push(bit sv, bit rv, bit hv, bit [39:0] r, bit [39:0] h,
                           bit [39:0] m, bit [13:0] q, bit remember);
            snapshot_t s;
            s = '{sv, rv, hv, r, h, m, q, 1'b0};
            pending.insert(pending.size(), s);
            if (remember)
            begin
                last_bps = '{r, h, m};
                last_ratio = q;
            end
        endfunction

        function void count_failure();
            if (fails != 8'd255)
                fails++;
            if (fails >= fail_limit)
                push(0, 0, 0, last_bps[0], last_bps[1], last_bps[2], last_ratio, 0);
        endfunction

        function void note_input(chrm_pkg::op_t op, bit [63:0] tot, bit [63:0] cac,
                                 bit [31:0] el);
            int start_count;
            bit [63:0] dr, dh, dm;
            bit rv, hv;
            bit [39:0] r, h, m;
            bit [13:0] q;
            start_count = pending.size();
            case (op)
                chrm_pkg::OP_IDLE:
                begin
                    if (active)
                        push(1, 0, 0, 0, 0, 0, 0, 1);
                    active = 0;
                    has_prev = 0;
                    prev_total = 0;
                    prev_cached = 0;
                    fails = 0;
                    clear_ring();
                end
                chrm_pkg::OP_FAIL:
                begin
                    if (!active)
                    begin
                        push(1, 0, 0, 0, 0, 0, 0, 1);
                        active = 1;
                    end
                    count_failure();
                end
                chrm_pkg::OP_GOOD:
                begin
                    if (!active)
                    begin
                        push(1, 0, 0, 0, 0, 0, 0, 1);
                        active = 1;
                    end
                    else
                    begin
                        rv = 0; hv = 0; r = 0; h = 0; m = 0; q = 0;
                        if (has_prev && el != 0)
                        begin
                            dr = (tot >= prev_total) ? tot - prev_total : 0;
                            dh = (cac >= prev_cached) ? cac - prev_cached : 0;
                            dm = (dr >= dh) ? dr - dh : 0;
                            rv = 1;
                            r = speed(dr, el);
                            h = speed(dh, el);
                            m = speed(dm, el);
                            total_rd = total_rd - ring_rd[slot] + dr;
                            total_hit = total_hit - ring_hit[slot] + dh;
                            ring_rd[slot] = dr;
                            ring_hit[slot] = dh;
                            slot = (slot + 1) % chrm_pkg::WINDOW_SAMPLES_DEFAULT;
                            if (total_rd != 0)
                            begin
                                hv = 1;
                                if (total_hit >= total_rd)
                                    q = chrm_pkg::RATIO_FULL;
                                else
                                    q = 14'(capped_div(128'(total_hit)
                                                       * 128'(chrm_pkg::RATIO_FULL),
                                                       total_rd,
                                                       64'(chrm_pkg::RATIO_FULL)));
                            end
                        end
                        push(1, rv, hv, r, h, m, q, 1);
                    end
                    prev_total = tot;
                    prev_cached = cac;
                    has_prev = 1;
                    fails = 0;
                end
                default: ;
            endcase
            if (pending.size() > start_count)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(snapshot_t got);
            snapshot_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [159:0] s_tdata = 0;
    logic [1:0]   s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    rate_scoreboard board = new();
    bit  hold_req = 0;
    bit  hold_done = 0;
    bit  sink_quiet = 0;
    bit [63:0] run_total, run_cached;

    cache_hit_rate_monitor dut (.*);

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 400);
    endfunction

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result({m_tuser[0], m_tuser[1], m_tuser[2], m_tdata[39:0],
                                m_tdata[79:40], m_tdata[119:80], m_tdata[133:120],
                                m_tlast});
    end

    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 0;
                repeat (3000) @(posedge clk);
                hold_done = 1;
            end
            g = sink_quiet ? 0 : pick_gap();
            m_tready <= (g == 0);
            if (g > 0)
            begin
                repeat (g) @(posedge clk);
                m_tready <= 1;
            end
            @(posedge clk);
        end
    end

    task automatic apb_write(chrm_pkg::reg_idx_t idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            chrm_pkg::REG_TICKS: board.tick_hz = val;
            default:             board.fail_limit = val[7:0];
        endcase
    endtask

    task automatic send(chrm_pkg::op_t op, logic [63:0] tot, logic [63:0] cac,
                        logic [31:0] el, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {el, cac, tot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(op, tot, cac, el);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    // Random ops; good-sample counters mostly rise, with an occasional step back.
    task automatic random_item(bit gaps);
        int r;
        logic [63:0] step;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: step = $urandom_range(0, 1000);
            1: step = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: step = $urandom;
            default: step = 64'd0;
        endcase
        if (r < 75)
        begin
            run_total += step;
            run_cached += step >> $urandom_range(0, 4);
            if ($urandom_range(0, 30) == 0)
                run_cached = run_total + $urandom_range(0, 99);
            if ($urandom_range(0, 40) == 0)
                run_total = {$urandom, $urandom};
            send(chrm_pkg::OP_GOOD, run_total, run_cached,
                 ($urandom_range(0, 20) == 0) ? 32'd0 :
                 ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 100000)), gaps);
        end
        else if (r < 92)
            send(chrm_pkg::OP_FAIL, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 gaps);
        else if (r < 97)
            send(chrm_pkg::OP_IDLE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 gaps);
        else
            send(chrm_pkg::OP_NONE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 gaps);
    endtask

    initial
    begin
        logic [63:0] ones;
        ones = '1;
        run_total = 0;
        run_cached = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: default registers.
        send(chrm_pkg::OP_NONE, ones, ones, '1, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_GOOD, 64'd1000, 64'd400, 32'd7, 0);
        send(chrm_pkg::OP_GOOD, 64'd500, 64'd900, 32'd10, 0);
        send(chrm_pkg::OP_GOOD, ones, ones, 32'd1, 0);
        send(chrm_pkg::OP_GOOD, ones, 64'd0, 32'd0, 0);
        send(chrm_pkg::OP_GOOD, 64'd0, 64'd0, 32'd5, 0);
        send(chrm_pkg::OP_GOOD, 64'd100, 64'd33, '1, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_IDLE, 0, 0, 0, 0);
        send(chrm_pkg::OP_IDLE, ones, ones, '1, 0);
        send(chrm_pkg::OP_GOOD, 64'd5, 64'd5, 32'd3, 0);
        drain();

        // Extremes of both registers.
        apb_write(chrm_pkg::REG_TICKS, 32'hFFFF_FFFF);
        apb_write(chrm_pkg::REG_LIMIT, 32'd1);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        send(chrm_pkg::OP_GOOD, 64'd10, 64'd3, 32'd1, 0);
        send(chrm_pkg::OP_GOOD, 64'd20, 64'd6, 32'd1, 0);
        send(chrm_pkg::OP_FAIL, 0, 0, 0, 0);
        drain();
        apb_write(chrm_pkg::REG_TICKS, 32'd1);
        apb_write(chrm_pkg::REG_LIMIT, 32'd255);
        for (int i = 0; i < 350; i++)
            random_item(1);
        drain();
        apb_write(chrm_pkg::REG_TICKS, 32'd0);
        for (int i = 0; i < 50; i++)
            random_item(1);
        drain();

        apb_write(chrm_pkg::REG_TICKS, chrm_pkg::TICKS_RESET);
        apb_write(chrm_pkg::REG_LIMIT, 32'(chrm_pkg::LIMIT_RESET));
        hold_req = 1;
        for (int i = 0; i < 20; i++)
            random_item(0);
        drain();
        for (int i = 0; i < 600; i++)
            random_item(1);
        drain();

        apb_write(chrm_pkg::REG_TICKS, $urandom);
        apb_write(chrm_pkg::REG_LIMIT, $urandom_range(1, 6));
        sink_quiet = 1;
        for (int i = 0; i < 300; i++)
            random_item(0);
        sink_quiet = 0;
        for (int i = 0; i < 350; i++)
            random_item(1);
        drain();

        if (board.errors == 0)
            $display("tb_cache_hit_rate_monitor passed");
        else
            $display("tb_cache_hit_rate_monitor failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("tb_cache_hit_rate_monitor failed");
        $finish;
    end
endmodule
